// ----- hdl/mep_pkg.sv -----
// Package for the Mandelbrot escape-time pixel unit: payload structs, fixed-point
// widths, frame constants, register indexes and the state type.
// No dependencies.
package mep_pkg;

  // Frame size used by the coordinate mapping (2 .. 1024 each)
  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 1024;

  localparam int DATA_W  = 32;  // Q6.26 word
  localparam int FRAC_W  = 26;
  localparam int COORD_W = 10;
  localparam int COUNT_W = 16;
  localparam int GRAY_W  = 8;

  // Mapping multiplicand: 3*column or 2*row
  localparam int M_W     = COORD_W + 2;
  // floor(m * 2^26 / dim) < 2^(M_W + FRAC_W - 1) since dim >= 2
  localparam int MAP_W   = M_W + FRAC_W - 1;
  localparam int DIM_MAX = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
  localparam int REM_W   = $clog2(DIM_MAX);

  // m * 2^26 = m * quo * dim + m * rem; m * rem < 2^TERM_W is divided by dim
  // through a reciprocal that is exact over TERM_W bits
  localparam int TERM_W   = M_W + REM_W;
  localparam int RCP_W    = TERM_W + 1;
  localparam int PROD_W   = TERM_W + RCP_W;
  localparam int SHIFT_WD = TERM_W + $clog2(FRAME_WIDTH);
  localparam int SHIFT_HT = TERM_W + $clog2(FRAME_HEIGHT);

  localparam logic [MAP_W-1:0] QUO_W  = MAP_W'((1 << FRAC_W) / FRAME_WIDTH);
  localparam logic [REM_W-1:0] REM_WD = REM_W'((1 << FRAC_W) % FRAME_WIDTH);
  localparam logic [MAP_W-1:0] QUO_H  = MAP_W'((1 << FRAC_W) / FRAME_HEIGHT);
  localparam logic [REM_W-1:0] REM_HT = REM_W'((1 << FRAC_W) % FRAME_HEIGHT);
  localparam logic [RCP_W-1:0] RCP_WD =
    RCP_W'(((64'd1 << SHIFT_WD) + 64'(FRAME_WIDTH) - 64'd1) / 64'(FRAME_WIDTH));
  localparam logic [RCP_W-1:0] RCP_HT =
    RCP_W'(((64'd1 << SHIFT_HT) + 64'(FRAME_HEIGHT) - 64'd1) / 64'(FRAME_HEIGHT));

  localparam logic signed [63:0] Q_ONE        = 64'sd1 <<< FRAC_W;
  localparam logic [63:0]        ESCAPE_BOUND = 64'd4 << 52;
  localparam logic [15:0]        GRAY_MULT    = 16'h0F0F;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_OFFSET     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATE_GAIN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

  localparam logic signed [DATA_W-1:0] ZOOM_RESET  = 32'sh0400_0000;
  localparam logic signed [DATA_W-1:0] GAIN_RESET  = 32'sh0400_0000;
  localparam logic [COUNT_W-1:0]       LIMIT_RESET = 16'd64;

  typedef struct packed {
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
  } mep_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] out_column;
    logic [COORD_W-1:0] out_row;
    logic [COUNT_W-1:0] iteration_count;
    logic [GRAY_W-1:0]  gray_level;
    logic               bounded;
  } mep_out_t;

  // Mapped coordinate offsets, floor(m * 2^26 / dim)
  typedef struct packed {
    logic [MAP_W-1:0] re;
    logic [MAP_W-1:0] im;
  } mep_map_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_MUL_XY,
    ST_ADD,
    ST_MUL_AG,
    ST_MUL_BG,
    ST_UPD,
    ST_OUT
  } mep_state_e;

endpackage

// ----- hdl/mep_coord_map.sv -----
// Pixel-to-plane offset mapping (depends on mep_pkg): floor(m * 2^26 / dim) for both axes as
// m*quo plus m*rem divided by dim through a reciprocal multiply; products, then sums, are registered.
module mep_coord_map (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [mep_pkg::M_W-1:0] m_re_i,
  input  logic [mep_pkg::M_W-1:0] m_im_i,
  output logic                  done_o,
  output mep_pkg::mep_map_t     map_o
);
  import mep_pkg::*;

  logic              busy_q;
  logic              done_q;
  logic [MAP_W-1:0]  mq_re_q, mq_im_q;
  logic [TERM_W-1:0] t_re_q, t_im_q;
  logic [PROD_W-1:0] rp_re, rp_im;
  mep_map_t          map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= start_i;
      done_q <= busy_q;
    end
  end

  // floor(t / dim) = (t * ceil(2^s / dim)) >> s over the whole range of t
  assign rp_re = PROD_W'(t_re_q) * PROD_W'(RCP_WD);
  assign rp_im = PROD_W'(t_im_q) * PROD_W'(RCP_HT);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mq_re_q <= MAP_W'(m_re_i) * QUO_W;
      mq_im_q <= MAP_W'(m_im_i) * QUO_H;
      t_re_q  <= TERM_W'(m_re_i) * TERM_W'(REM_WD);
      t_im_q  <= TERM_W'(m_im_i) * TERM_W'(REM_HT);
    end else if (busy_q) begin
      map_q.re <= mq_re_q + MAP_W'(rp_re >> SHIFT_WD);
      map_q.im <= mq_im_q + MAP_W'(rp_im >> SHIFT_HT);
    end
  end

  assign done_o = done_q;
  assign map_o  = map_q;

endmodule

// ----- hdl/mandelbrot_escape_pixel_unit.sv -----
// Sequence per request: the coordinate mapping (mep_coord_map), then iterations that each use
// one shared 32x32 multiplier five times (x*x, y*y, x*y, a*gain, b*gain), then the output state.
// A new request is accepted only in idle, after the previous pixel has left the sequencer;
// a finished result waits in the output register while the next request is
// accepted. Reset (rst_ni, async low) returns the sequencer to idle, empties the output and
// loads the register reset values. Top level; uses mep_pkg and mep_coord_map.
module mandelbrot_escape_pixel_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mep_pkg::mep_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mep_pkg::mep_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mep_pkg::DATA_W-1:0]    cfg_data_i
);
  import mep_pkg::*;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
    if (v > SAT_MAX) return 32'sh7FFF_FFFF;
    else if (v < SAT_MIN) return 32'sh8000_0000;
    else return v[DATA_W-1:0];
  endfunction

  mep_state_e state_q, state_d;

  logic signed [DATA_W-1:0] zoom_q, gain_q;
  logic [COUNT_W-1:0]       limit_q;

  logic                     out_valid_q, out_valid_d;
  mep_out_t                 out_q, out_d;

  logic [COORD_W-1:0]       col_q, col_d, row_q, row_d;
  logic signed [34:0]       off_q, off_d;
  logic signed [DATA_W-1:0] cr_q, cr_d, ci_q, ci_d;
  logic signed [DATA_W-1:0] x_q, x_d, y_q, y_d, a_q, a_d, b_q, b_d;
  logic signed [63:0]       p_q, p_d, xx_q, xx_d, diff_q, diff_d;
  logic                     esc_q, esc_d;
  logic [COUNT_W-1:0]       count_q, count_d;

  logic signed [DATA_W-1:0] mul_a, mul_b;
  logic signed [63:0]       prod;
  logic [63:0]              sq_sum;
  logic [COUNT_W-1:0]       count_inc;
  logic                     accept;
  logic                     out_free;
  logic                     map_done;
  mep_map_t                 map;

  assign accept   = (state_q == ST_IDLE) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;

  mep_coord_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(accept),
    .m_re_i ({2'b00, in_data_i.column} + {1'b0, in_data_i.column, 1'b0}),
    .m_im_i ({1'b0, in_data_i.row, 1'b0}),
    .done_o (map_done),
    .map_o  (map)
  );

  // Shared multiplier operand select
  always_comb begin
    case (state_q)
      ST_MUL_XX: begin mul_a = x_q; mul_b = x_q;    end
      ST_MUL_YY: begin mul_a = y_q; mul_b = y_q;    end
      ST_MUL_XY: begin mul_a = x_q; mul_b = y_q;    end
      ST_MUL_AG: begin mul_a = a_q; mul_b = gain_q; end
      ST_MUL_BG: begin mul_a = b_q; mul_b = gain_q; end
      default:   begin mul_a = x_q; mul_b = x_q;    end
    endcase
  end

  assign prod      = mul_a * mul_b;
  assign sq_sum    = $unsigned(xx_q) + $unsigned(p_q);
  assign count_inc = count_q + COUNT_W'(1);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    col_d       = col_q;
    row_d       = row_q;
    off_d       = off_q;
    cr_d        = cr_q;
    ci_d        = ci_q;
    x_d         = x_q;
    y_d         = y_q;
    a_d         = a_q;
    b_d         = b_q;
    p_d         = p_q;
    xx_d        = xx_q;
    diff_d      = diff_q;
    esc_d       = esc_q;
    count_d     = count_q;

    if (!out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          col_d   = in_data_i.column;
          row_d   = in_data_i.row;
          off_d   = -(35'(zoom_q) <<< 1) - 35'(zoom_q);
          state_d = ST_MAP;
        end
      end
      ST_MAP: begin
        if (map_done) begin
          cr_d    = sat32(64'(off_q) + 64'($signed({1'b0, map.re})));
          ci_d    = sat32(64'($signed({1'b0, map.im})) - Q_ONE);
          x_d     = '0;
          y_d     = '0;
          count_d = '0;
          state_d = (limit_q == '0) ? ST_OUT : ST_MUL_XX;
        end
      end
      ST_MUL_XX: begin
        p_d     = prod;
        state_d = ST_MUL_YY;
      end
      ST_MUL_YY: begin
        xx_d    = p_q;
        p_d     = prod;
        state_d = ST_MUL_XY;
      end
      ST_MUL_XY: begin
        diff_d  = xx_q - p_q;
        esc_d   = sq_sum > ESCAPE_BOUND;
        p_d     = prod;
        state_d = ST_ADD;
      end
      ST_ADD: begin
        if (esc_q) begin
          state_d = ST_OUT;
        end else begin
          a_d     = sat32((diff_q >>> FRAC_W) + 64'(cr_q));
          b_d     = sat32((p_q >>> (FRAC_W - 1)) + 64'(ci_q));
          state_d = ST_MUL_AG;
        end
      end
      ST_MUL_AG: begin
        p_d     = prod;
        state_d = ST_MUL_BG;
      end
      ST_MUL_BG: begin
        x_d     = sat32(p_q >>> FRAC_W);
        p_d     = prod;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        y_d     = sat32(p_q >>> FRAC_W);
        count_d = count_inc;
        state_d = (count_inc == limit_q) ? ST_OUT : ST_MUL_XX;
      end
      ST_OUT: begin
        // hold until the output register is free
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.out_column      = col_q;
          out_d.out_row         = row_q;
          out_d.iteration_count = count_q;
          out_d.bounded         = (count_q == limit_q);
          out_d.gray_level      = (count_q == limit_q) ? '0 :
                                  GRAY_W'(count_q[7:0] * GRAY_MULT[7:0]);
          state_d               = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zoom_q  <= ZOOM_RESET;
      gain_q  <= GAIN_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_ZOOM_OFFSET:     zoom_q  <= cfg_data_i;
        CFG_ITERATE_GAIN:    gain_q  <= cfg_data_i;
        CFG_ITERATION_LIMIT: limit_q <= cfg_data_i[COUNT_W-1:0];
        default:             ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    col_q   <= col_d;
    row_q   <= row_d;
    off_q   <= off_d;
    cr_q    <= cr_d;
    ci_q    <= ci_d;
    x_q     <= x_d;
    y_q     <= y_d;
    a_q     <= a_d;
    b_q     <= b_d;
    p_q     <= p_d;
    xx_q    <= xx_d;
    diff_q  <= diff_d;
    esc_q   <= esc_d;
    count_q <= count_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

`ifndef SYNTHESIS
  a_count_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL_XX) |-> (count_q < limit_q))
    else $error("iteration started with count at or above limit");

  a_bounded_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.bounded) |-> (out_data_o.gray_level == '0))
    else $error("bounded pixel with nonzero gray level");

  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT && out_valid_q && out_stall_i) |=> (state_q == ST_OUT))
    else $error("result left while output register still occupied");
`endif

endmodule

// ----- tb/sv/mep_escape_check.sv -----
// Request/result checker for the Mandelbrot escape-time pixel unit.
// Shadows the three registers, predicts each pixel in Q6.26 and compares results in order.
// Depends on mep_pkg.
module mep_escape_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  mep_pkg::mep_in_t              in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  mep_pkg::mep_out_t             out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [mep_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mep_pkg::DATA_W-1:0]    cfg_data_i,
  output int unsigned                   mismatch_count_o,
  output int unsigned                   results_o,
  output int unsigned                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import mep_pkg::*;

  localparam logic [63:0]        ESCAPE_SQ     = 64'd4 << 52;
  localparam logic signed [31:0] Q_UNIT        = 32'sh0400_0000;
  localparam logic [15:0]        LIMIT_DEFAULT = 16'd64;
  localparam int unsigned        GRAY_STEP     = 32'h0F0F;
  localparam int unsigned        REPORT_MAX    = 10;

  logic signed [31:0] zoom_q;
  logic signed [31:0] gain_q;
  logic [15:0]        limit_q;
  mep_out_t           awaited_px [$];
  int unsigned        mismatches = 0;
  int unsigned        results = 0;

  function automatic logic signed [63:0] clamp_word(input logic signed [63:0] v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic mep_out_t escape_pixel(input mep_in_t px, input logic signed [31:0] zoom,
                                            input logic signed [31:0] gain32,
                                            input logic [15:0] limit);
    logic signed [63:0] col, row, cr, ci, x, y, xx, yy, a, b, gain;
    int unsigned n;
    mep_out_t res;
    col  = {54'd0, px.column};
    row  = {54'd0, px.row};
    gain = gain32;
    cr = clamp_word(zoom * -64'sd3 + ((col * 64'sd3) <<< 26) / FRAME_WIDTH);
    ci = clamp_word(((row * 64'sd2) <<< 26) / FRAME_HEIGHT - (64'sd1 <<< 26));
    x = 0;
    y = 0;
    n = 0;
    while (n < limit) begin
      xx = x * x;
      yy = y * y;
      if ($unsigned(xx) + $unsigned(yy) > ESCAPE_SQ) break;
      a = clamp_word(((xx - yy) >>> 26) + cr);
      b = clamp_word(((x * y) >>> 25) + ci);
      x = clamp_word((a * gain) >>> 26);
      y = clamp_word((b * gain) >>> 26);
      n++;
    end
    res.out_column      = px.column;
    res.out_row         = px.row;
    res.iteration_count = n[15:0];
    res.bounded         = (n == limit);
    res.gray_level      = res.bounded ? 8'd0 : 8'(n * GRAY_STEP);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    mep_out_t want;
    if (!rst_ni) begin
      zoom_q  <= Q_UNIT;
      gain_q  <= Q_UNIT;
      limit_q <= LIMIT_DEFAULT;
      awaited_px.delete();
      mismatch_count_o <= 0;
      results_o        <= 0;
      pending_o        <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_ZOOM_OFFSET:     zoom_q  <= cfg_data_i;
          CFG_ITERATE_GAIN:    gain_q  <= cfg_data_i;
          CFG_ITERATION_LIMIT: limit_q <= cfg_data_i[15:0];
          default: ;  // drop writes to unknown indexes
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_px.push_back(escape_pixel(in_data_i, zoom_q, gain_q, limit_q));
      end
      if (out_valid_i && !out_stall_i) begin
        results++;
        if (awaited_px.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: result for pixel (%0d,%0d) with no request pending", $time,
                     out_data_i.out_column, out_data_i.out_row);
          end
        end else begin
          want = awaited_px.pop_front();
          if (want.out_column !== out_data_i.out_column || want.out_row !== out_data_i.out_row ||
              want.iteration_count !== out_data_i.iteration_count ||
              want.gray_level !== out_data_i.gray_level || want.bounded !== out_data_i.bounded)
          begin
            mismatches++;
            if (mismatches <= REPORT_MAX) begin
              $display("%0t: expected col %0d row %0d count %0d gray %0d bounded %0b", $time,
                       want.out_column, want.out_row, want.iteration_count, want.gray_level,
                       want.bounded);
              $display("%0t:   actual col %0d row %0d count %0d gray %0d bounded %0b", $time,
                       out_data_i.out_column, out_data_i.out_row, out_data_i.iteration_count,
                       out_data_i.gray_level, out_data_i.bounded);
            end
          end
        end
      end
      mismatch_count_o <= mismatches;
      results_o        <= results;
      pending_o        <= awaited_px.size();
    end
  end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the escape-time pixel unit testbench: clock, reset, register writes and pixel traffic.
// Instantiates mandelbrot_escape_pixel_unit and mep_escape_check; uses mep_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mep_pkg::*;

  localparam int CLK_PERIOD      = 20;
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int HOLD_OFF_CYCLES = 2000;
  localparam int DRAIN_CYCLES    = 100;
  localparam int NUM_PHASES      = 14;

  localparam logic [DATA_W-1:0]    Q_UNIT     = 32'h0400_0000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam mep_in_t EDGE_PX [12] = '{
    {10'd0, 10'd0}, {10'd1023, 10'd1023}, {10'd0, 10'd1023}, {10'd1023, 10'd0},
    {10'd512, 10'd512}, {10'd683, 10'd512}, {10'd768, 10'd512}, {10'd1023, 10'd512},
    {10'd341, 10'd0}, {10'd342, 10'd600}, {10'h155, 10'h2AA}, {10'h2AA, 10'h155}
  };
  // saturating offsets and gains first, then randomized settings
  localparam logic [DATA_W-1:0] ZOOM_SET [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, Q_UNIT};
  localparam logic [DATA_W-1:0] GAIN_SET [4] = '{Q_UNIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
  localparam int unsigned LIMIT_SET [NUM_PHASES] = '{
    1, 12, 20, 9, 16, 64, 40, 2, 48, 100, 7, 250, 24, 64
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  mep_in_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  mep_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0]    cfg_data = '0;

  int unsigned mismatch_count, results, pending;
  int unsigned issued = 0;
  int unsigned settings = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served = 0;

  mandelbrot_escape_pixel_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  mep_escape_check escape_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .out_data_i       (out_data),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatch_count),
    .results_o        (results),
    .pending_o        (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver side: random stalls, or one long hold-off when asked for
  initial begin : stall_drive
    forever begin
      @(posedge clk);
      if (hold_served != hold_requests) begin
        hold_served++;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic push_pixel(input mep_in_t px);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    issued++;
  endtask

  // Keep valid high across back-to-back writes; drop it after the last one
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val,
                           input bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (results != issued) @(posedge clk);
  endtask

  function automatic logic [DATA_W-1:0] near_unity();
    if ($urandom_range(0, 3) == 0) return $urandom();
    return Q_UNIT + DATA_W'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
  endfunction

  initial begin : stimulus
    mep_in_t           px;
    int unsigned       lim, n_items, mode;
    logic [DATA_W-1:0] zoom_w, gain_w;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: corners, alternating bits, points on and off the set
    foreach (EDGE_PX[i]) push_pixel(EDGE_PX[i]);
    drain();
    settings++;

    // zero limit: no iteration at all
    cfg_write(CFG_ITERATION_LIMIT, '0, 1'b1);
    push_pixel({10'd0, 10'd0});
    push_pixel({10'd512, 10'd512});
    push_pixel({10'd1023, 10'd1023});
    push_pixel(20'($urandom()));
    drain();
    settings++;

    // unknown index must leave the registers alone; then the largest limit
    // with pixels left of the set so every one escapes at once
    cfg_write(CFG_UNUSED, $urandom(), 1'b0);
    cfg_write(CFG_ITERATION_LIMIT, 32'h0000_FFFF, 1'b1);
    push_pixel({10'd0, 10'd1023});
    push_pixel({10'd300, 10'd0});
    repeat (4) push_pixel({10'($urandom_range(0, 300)), 10'($urandom())});
    drain();
    settings++;

    for (int p = 0; p < NUM_PHASES; p++) begin
      lim = LIMIT_SET[p];
      if (p < 4) begin
        zoom_w  = ZOOM_SET[p];
        gain_w  = GAIN_SET[p];
        n_items = 40;
      end else begin
        zoom_w  = near_unity();
        gain_w  = near_unity();
        n_items = (lim >= 250) ? 40 : (lim >= 100) ? 80 : 130;
      end
      cfg_write(CFG_ZOOM_OFFSET, zoom_w, 1'b0);
      cfg_write(CFG_ITERATE_GAIN, gain_w, 1'b0);
      cfg_write(CFG_ITERATION_LIMIT, lim, 1'b1);

      mode = p % 4;
      send_idle_pct = (mode == 1) ? 68 : (mode == 3) ? 12 : 0;
      stall_pct     = (mode == 2) ? 68 : (mode == 3) ? 12 : 0;
      // short pixels here, so the unit backs up quickly under the hold-off
      if (lim == 2) hold_requests++;

      repeat (n_items) push_pixel(20'($urandom()));
      drain();
      settings++;
    end

    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d pixel requests under %0d register settings,", issued, settings);
    $display("limits 0 to 65535, saturating offsets and gains, idle and stall mixes.");
    if (mismatch_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/mep_pkg.sv
hdl/mep_coord_map.sv
hdl/mandelbrot_escape_pixel_unit.sv
tb/sv/mep_escape_check.sv
tb/sv/tb.sv
